>>> src/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg - shared types and constants for the multi-stack shared store
// Field widths, operation and status codes, and the command/status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mss_pkg;

  // Default storage sizes (top-level parameter defaults)
  localparam int CAPACITY_DEF   = 16;
  localparam int MAX_STACKS_DEF = 16;

  // Fixed field widths
  localparam int OP_W      = 2;
  localparam int IDX_W     = 4;
  localparam int DATA_W    = 32;
  localparam int STAT_W    = 2;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;

  // Register reset values
  localparam int NUM_STACKS_RST = 1;
  localparam int TOTAL_SIZE_RST = 16;

  // One quotient bit per divider step
  localparam int DIV_STEPS = CFG_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STACKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SIZE = 2'd1;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_DISPLAY = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  // Source of the result data word
  typedef enum logic [1:0] {
    DSEL_ZERO = 2'd0,
    DSEL_ONES = 2'd1,
    DSEL_MEM  = 2'd2
  } dsel_t;

  // Controller -> datapath
  typedef struct packed {
    logic    load_item;
    logic    cfg_wr;
    logic    div_init;
    logic    div_step;
    logic    div_finish;
    logic    push;
    logic    pop;
    logic    disp_start;
    logic    disp_next;
    logic    emit;
    dsel_t   emit_sel;
    status_t emit_status;
    logic    emit_last;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    op_t  op;
    logic bad;
    logic full;
    logic empty;
    logic disp_last;
    logic div_done;
  } sts_t;

endpackage

`default_nettype wire

>>> src/mss_ctrl.sv
// ----------------------------------------------------------------------------
// mss_ctrl - operation sequencer
// Decodes each accepted item against the datapath status, steps the
// partition divider after a register write and paces display read-out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mss_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic                           cfg_valid,
  input  wire logic [mss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire mss_pkg::sts_t                  sts,
  output mss_pkg::cmd_t                       cmd,
  output logic                                busy,
  output logic                                cfg_ready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP_OUT,
    S_DISP,
    S_DIV_INIT,
    S_DIV_STEP
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !start;

  // Decode next state and datapath commands
  always_comb begin
    cmd             = '0;
    cmd.emit_sel    = mss_pkg::DSEL_ZERO;
    cmd.emit_status = mss_pkg::ST_OK;
    state_nxt       = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end else if (cfg_valid) begin
          if ((cfg_index == mss_pkg::CFG_NUM_STACKS) ||
              (cfg_index == mss_pkg::CFG_TOTAL_SIZE)) begin
            cmd.cfg_wr = 1'b1;
            state_nxt  = S_DIV_INIT;
          end
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        if (sts.op == mss_pkg::OP_NONE) begin
          // reserved code: drop without a result
          state_nxt = S_IDLE;
        end else if (sts.bad) begin
          cmd.emit        = 1'b1;
          cmd.emit_last   = 1'b1;
          cmd.emit_status = mss_pkg::ST_BAD_INDEX;
        end else begin
          case (sts.op)
            mss_pkg::OP_PUSH: begin
              cmd.emit      = 1'b1;
              cmd.emit_last = 1'b1;
              if (sts.full) begin
                cmd.emit_status = mss_pkg::ST_FULL;
              end else begin
                cmd.push = 1'b1;
              end
            end
            mss_pkg::OP_POP: begin
              if (sts.empty) begin
                cmd.emit        = 1'b1;
                cmd.emit_last   = 1'b1;
                cmd.emit_status = mss_pkg::ST_EMPTY;
                cmd.emit_sel    = mss_pkg::DSEL_ONES;
              end else begin
                cmd.pop   = 1'b1;
                state_nxt = S_POP_OUT;
              end
            end
            mss_pkg::OP_DISPLAY: begin
              if (sts.empty) begin
                cmd.emit        = 1'b1;
                cmd.emit_last   = 1'b1;
                cmd.emit_status = mss_pkg::ST_EMPTY;
              end else begin
                cmd.disp_start = 1'b1;
                state_nxt      = S_DISP;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_POP_OUT: begin
        cmd.emit      = 1'b1;
        cmd.emit_last = 1'b1;
        cmd.emit_sel  = mss_pkg::DSEL_MEM;
        state_nxt     = S_IDLE;
      end
      S_DISP: begin
        // emit the element read last cycle, fetch the next one
        cmd.emit      = 1'b1;
        cmd.emit_sel  = mss_pkg::DSEL_MEM;
        cmd.emit_last = sts.disp_last;
        if (sts.disp_last) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.disp_next = 1'b1;
        end
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        if (sts.div_done) begin
          cmd.div_finish = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/mss_datapath.sv
// ----------------------------------------------------------------------------
// mss_datapath - element store, fill counters and partition divider
// Holds the configuration, the per-stack fill counts, the shared element
// memory with a registered read port and the result output registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mss_datapath #(
  parameter int CAPACITY   = mss_pkg::CAPACITY_DEF,
  parameter int MAX_STACKS = mss_pkg::MAX_STACKS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [mss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mss_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic [mss_pkg::OP_W-1:0]       in_operation,
  input  wire logic [mss_pkg::IDX_W-1:0]      in_stack_index,
  input  wire logic signed [mss_pkg::DATA_W-1:0] in_push_value,
  input  wire mss_pkg::cmd_t                  cmd,
  output mss_pkg::sts_t                       sts,
  output logic                                out_valid,
  output logic [mss_pkg::STAT_W-1:0]          out_status,
  output logic signed [mss_pkg::DATA_W-1:0]   out_data_out,
  output logic                                out_last
);

  localparam int CW     = mss_pkg::CFG_W;
  localparam int IW     = mss_pkg::IDX_W;
  localparam int DW     = mss_pkg::DATA_W;
  localparam int BASE_W = IW + CW;
  // stack_index reaches only 2**IW stacks
  localparam int NUM_FILL   = (MAX_STACKS < (1 << IW)) ? MAX_STACKS : (1 << IW);
  localparam int FIDX_W     = (NUM_FILL > 1) ? $clog2(NUM_FILL) : 1;
  localparam int FILL_DEPTH = 1 << FIDX_W;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int MEM_DEPTH  = 1 << ADDR_W;
  localparam int TS_RST     = (CAPACITY < mss_pkg::TOTAL_SIZE_RST) ?
                              CAPACITY : mss_pkg::TOTAL_SIZE_RST;
  localparam int NS_RST     = (MAX_STACKS < mss_pkg::NUM_STACKS_RST) ?
                              MAX_STACKS : mss_pkg::NUM_STACKS_RST;
  localparam int SLOTS_RST  = TS_RST / NS_RST;

  // Configuration and partition size
  logic [CW-1:0] num_stacks_r;
  logic [CW-1:0] total_size_r;
  logic [CW-1:0] slots_r;
  logic [CW-1:0] ns_eff;
  logic [CW-1:0] ts_eff;

  // Divider
  logic [CW-1:0]                  div_q_r;
  logic [CW-1:0]                  div_rem_r;
  logic [mss_pkg::DCNT_W-1:0]     div_cnt_r;
  logic [CW:0]                    rem_sh;
  logic                           rem_ge;

  // Fill counts and current item
  logic [CW-1:0]          fill_r [FILL_DEPTH];
  logic [CW-1:0]          fill_cur;
  logic [FIDX_W-1:0]      fidx;
  logic [mss_pkg::OP_W-1:0] op_r;
  logic [IW-1:0]          k_r;
  logic [DW-1:0]          val_r;
  logic [CW-1:0]          idx_r;

  // Element store
  logic [DW-1:0]          mem [MEM_DEPTH];
  logic [DW-1:0]          rdata_r;
  logic [BASE_W-1:0]      base;
  logic [BASE_W-1:0]      addr_push;
  logic [BASE_W-1:0]      addr_rd;
  logic                   rd_en;

  // Output registers
  logic                   out_valid_r;
  logic [mss_pkg::STAT_W-1:0] out_status_r;
  logic [DW-1:0]          out_data_r;
  logic                   out_last_r;

  // Saturate registers against the storage limits
  assign ns_eff = (int'(num_stacks_r) > MAX_STACKS) ? CW'(MAX_STACKS) : num_stacks_r;
  assign ts_eff = (int'(total_size_r) > CAPACITY) ? CW'(CAPACITY) : total_size_r;

  // Current stack view
  assign fidx      = k_r[FIDX_W-1:0];
  assign fill_cur  = fill_r[fidx];
  assign base      = BASE_W'(k_r) * BASE_W'(slots_r);
  assign addr_push = base + BASE_W'(fill_cur);

  always_comb begin
    addr_rd = base;
    if (cmd.pop) begin
      addr_rd = base + BASE_W'(fill_cur) - BASE_W'(1);
    end else if (cmd.disp_next) begin
      addr_rd = base + BASE_W'(idx_r) + BASE_W'(1);
    end
  end
  assign rd_en = cmd.pop | cmd.disp_start | cmd.disp_next;

  // Status to the controller
  assign sts.op        = mss_pkg::op_t'(op_r);
  assign sts.bad       = ({1'b0, k_r} >= ns_eff);
  assign sts.full      = (fill_cur >= slots_r);
  assign sts.empty     = (fill_cur == '0);
  assign sts.disp_last = (CW'(idx_r + CW'(1)) == fill_cur);
  assign sts.div_done  = (div_cnt_r == '0);

  // Restoring divide step: one quotient bit per cycle
  assign rem_sh = {div_rem_r, div_q_r[CW-1]};
  assign rem_ge = (rem_sh >= {1'b0, ns_eff});

  // Hold configuration, partition size and divider control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_stacks_r <= CW'(mss_pkg::NUM_STACKS_RST);
      total_size_r <= CW'(mss_pkg::TOTAL_SIZE_RST);
      slots_r      <= CW'(SLOTS_RST);
      div_cnt_r    <= '0;
    end else begin
      if (cmd.cfg_wr) begin
        if (cfg_index == mss_pkg::CFG_NUM_STACKS) begin
          num_stacks_r <= cfg_data;
        end else begin
          total_size_r <= cfg_data;
        end
      end
      if (cmd.div_init) begin
        div_cnt_r <= mss_pkg::DCNT_W'(mss_pkg::DIV_STEPS);
      end else if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r - mss_pkg::DCNT_W'(1);
      end
      if (cmd.div_finish) begin
        slots_r <= (ns_eff == '0) ? '0 : div_q_r;
      end
    end
  end

  // Advance divider datapath
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      div_q_r   <= ts_eff;
      div_rem_r <= '0;
    end else if (cmd.div_step) begin
      div_q_r   <= {div_q_r[CW-2:0], rem_ge};
      div_rem_r <= rem_ge ? CW'(rem_sh - {1'b0, ns_eff}) : rem_sh[CW-1:0];
    end
  end

  // Update fill counts; any register write empties every stack
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FILL_DEPTH; i++) begin
        fill_r[i] <= '0;
      end
    end else if (cmd.cfg_wr) begin
      for (int i = 0; i < FILL_DEPTH; i++) begin
        fill_r[i] <= '0;
      end
    end else if (cmd.push) begin
      fill_r[fidx] <= fill_cur + CW'(1);
    end else if (cmd.pop) begin
      fill_r[fidx] <= fill_cur - CW'(1);
    end
  end

  // Capture item and display position
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r  <= in_operation;
      k_r   <= in_stack_index;
      val_r <= in_push_value;
    end
    if (cmd.disp_start) begin
      idx_r <= '0;
    end else if (cmd.disp_next) begin
      idx_r <= idx_r + CW'(1);
    end
  end

  // Element store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[addr_push[ADDR_W-1:0]] <= val_r;
    end
    if (rd_en) begin
      rdata_r <= mem[addr_rd[ADDR_W-1:0]];
    end
  end

  // Drive result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      out_last_r   <= cmd.emit_last;
      case (cmd.emit_sel)
        mss_pkg::DSEL_ONES: out_data_r <= '1;
        mss_pkg::DSEL_MEM:  out_data_r <= rdata_r;
        default:            out_data_r <= '0;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_data_out = out_data_r;
  assign out_last     = out_last_r;

endmodule

`default_nettype wire

>>> src/multi_stack_shared_store.sv
// ----------------------------------------------------------------------------
// multi_stack_shared_store - LIFO stacks in fixed partitions of one store
//
//   channel   ports                                       handshake
//   input     in_operation, in_stack_index, in_push_value start & !busy
//   result    out_status, out_data_out, out_last          out_valid, 1 cycle
//   config    cfg_index, cfg_data                         cfg_valid & cfg_ready
//
// Push, full push, empty pop, empty display and bad index pass through the
// execute state before the next accept; pop adds an output state for the
// registered store read. Display of n elements: n beats, one read and one
// beat per cycle. A register write reruns a bit-serial divider for the
// partition size; busy stays high while it runs. Reset is synchronous; after
// reset every stack is empty. The receiver cannot stall; each beat shows once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multi_stack_shared_store #(
  parameter int CAPACITY   = mss_pkg::CAPACITY_DEF,
  parameter int MAX_STACKS = mss_pkg::MAX_STACKS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [mss_pkg::OP_W-1:0]          in_operation,
  input  wire logic [mss_pkg::IDX_W-1:0]         in_stack_index,
  input  wire logic signed [mss_pkg::DATA_W-1:0] in_push_value,
  output logic                                   out_valid,
  output logic [mss_pkg::STAT_W-1:0]             out_status,
  output logic signed [mss_pkg::DATA_W-1:0]      out_data_out,
  output logic                                   out_last,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [mss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mss_pkg::CFG_W-1:0]         cfg_data
);

  mss_pkg::cmd_t cmd;
  mss_pkg::sts_t sts;

  // Sequence operations
  mss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .cfg_ready (cfg_ready)
  );

  // Store, counters and result registers
  mss_datapath #(
    .CAPACITY   (CAPACITY),
    .MAX_STACKS (MAX_STACKS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_operation   (in_operation),
    .in_stack_index (in_stack_index),
    .in_push_value  (in_push_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_data_out   (out_data_out),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire
